/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define SLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Concurrent assertion that a condition never shows outside reset.
`define SLS_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* sv/slstat_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor log statistics package
// Sizes, register indexes, reset values and sequencer states of the block.
// ----------------------------------------------------------------------------
package slstat_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int ENTRY_W       = 16;

  localparam int TREND_SPAN    = 6;
  localparam int TREND_HALF    = 3;
  localparam int FORECAST_SPAN = 5;
  localparam int FCNT_W        = 3;
  // Five bytes summed need eleven bits.
  localparam int SUM_W         = 11;
  localparam int STEP_W        = $clog2(SUM_W);

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [15:0] RST_STORE_INTERVAL = 16'd10;
  localparam logic [7:0]  RST_COLD_BELOW     = 8'd20;
  localparam logic [7:0]  RST_HOT_ABOVE      = 8'd28;
  localparam logic [7:0]  RST_DRY_BELOW      = 8'd40;
  localparam logic [7:0]  RST_HUMID_ABOVE    = 8'd70;
  localparam logic [9:0]  RST_TREND_LIMIT    = 10'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STORE_INTERVAL = 3'd0,
    CFG_COLD_BELOW     = 3'd1,
    CFG_HOT_ABOVE      = 3'd2,
    CFG_DRY_BELOW      = 3'd3,
    CFG_HUMID_ABOVE    = 3'd4,
    CFG_TREND_LIMIT    = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_GATHER,
    ST_DIVIDE,
    ST_SCAN,
    ST_MASK,
    ST_RESULT
  } state_t;

endpackage

/* sv/slstat_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module slstat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/sensor_log_statistics.sv */
// ----------------------------------------------------------------------------
// Sensor log statistics
// Threshold indicators and a logged history of temperature and humidity.
// ----------------------------------------------------------------------------
// Usage: one reading arrives per transfer on the sample channel (read_ok,
// temperature, humidity, qualified by sample_valid and sample_stall). Each
// reading gives exactly one transfer on the result channel. Configuration
// registers are written through cfg_write, cfg_index and cfg_data while the
// block is idle.
// A reading that is not stored passes the mask state before its result is
// offered. A stored reading runs the shared unit through a write, a gather
// of the newest six entries, the divider steps for the two forecasts, a scan
// of the stored entries for the extremes and the mask, in that order. The
// shared unit uses the single history memory port and takes one divider
// step per cycle.
// sample_stall is high from a transfer until its result has been taken, so
// the block holds one reading at a time. While result_stall is high the
// result stays valid and unchanged. Reset clears the counters and the held
// statistics and loads the configuration defaults; the history memory is not cleared.
// ----------------------------------------------------------------------------
module sensor_log_statistics
  import slstat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic                  read_ok,
  input  logic [7:0]            temperature,
  input  logic [7:0]            humidity,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [5:0]            led_mask,
  output logic signed [10:0]    trend_diff,
  output logic [7:0]            forecast_temp,
  output logic [7:0]            forecast_hum,
  output logic [7:0]            temp_low,
  output logic [7:0]            temp_high,
  output logic [7:0]            hum_low,
  output logic [7:0]            hum_high,
  output logic [5:0]            entries_stored
);

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(HISTORY_DEPTH);

  state_t state, state_next;

  // Configuration registers.
  logic [15:0] store_interval;
  logic [7:0]  cold_below, hot_above, dry_below, humid_above;
  logic [9:0]  trend_limit;

  // Logging state.
  logic [15:0]      good_read_count;
  logic [IDX_W-1:0] write_slot;
  logic [CNT_W-1:0] valid_count;

  // The reading under work.
  logic       cur_ok;
  logic [7:0] cur_temp, cur_hum;

  // Read sequencing: issue_cnt walks the reads, rd_vld and rd_k are registered
  // so that they line up with the registered memory output.
  logic [CNT_W-1:0] issue_cnt, rd_k, rd_total;
  logic             rd_vld, rd_issue, walk_done;

  // Accumulators and divider.
  logic [SUM_W-1:0]   sum_t, sum_h;
  logic signed [10:0] trend_acc;
  logic [SUM_W-1:0]   div_q, div_q_next;
  logic [2:0]         div_rem, div_rem_next;
  logic [3:0]         div_trial;
  logic [STEP_W-1:0]  div_step;
  logic               div_hum, div_ge;
  logic [FCNT_W-1:0]  fcount;
  logic               trend_on;

  // Memory ports.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_q;
  logic [IDX_W:0]     slot_ext;

  // Sample transfer decode.
  logic [15:0] cnt_inc;
  logic        store_hit;
  logic [10:0] trend_mag;

  logic signed [10:0] held_trend;

  assign sample_stall   = (state != ST_IDLE);
  assign trend_diff     = held_trend;
  assign entries_stored = 6'(valid_count);

  assign cnt_inc   = good_read_count + 16'd1;
  assign store_hit = read_ok && (cnt_inc >= store_interval);

  assign trend_on = (valid_count >= CNT_W'(TREND_SPAN));
  assign fcount   = (valid_count >= CNT_W'(FORECAST_SPAN)) ? FCNT_W'(FORECAST_SPAN)
                                                           : FCNT_W'(valid_count);

  // The gather pass reads six entries once six are stored, else all of them.
  assign rd_total  = (state == ST_SCAN) ? valid_count
                   : (trend_on ? CNT_W'(TREND_SPAN) : valid_count);
  assign walk_done = (issue_cnt == rd_total) && !rd_vld;

  // Slot of the k-th newest entry, k taken from the issue counter.
  assign slot_ext = {1'b0, write_slot} + DEPTH_X - (IDX_W + 1)'(1)
                  - (IDX_W + 1)'(issue_cnt);

  // One restoring divider step: the forecast count is the divisor.
  assign div_trial    = {div_rem, div_q[SUM_W-1]};
  assign div_ge       = (div_trial >= {1'b0, fcount});
  assign div_rem_next = div_ge ? 3'(div_trial - {1'b0, fcount}) : div_trial[2:0];
  assign div_q_next   = {div_q[SUM_W-2:0], div_ge};

  assign trend_mag = held_trend[10] ? 11'(-held_trend) : held_trend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    rd_issue   = 1'b0;
    ram_raddr  = issue_cnt[IDX_W-1:0];
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = store_hit ? ST_STORE : ST_MASK;
        end
      end
      ST_STORE: begin
        ram_we     = 1'b1;
        state_next = ST_GATHER;
      end
      ST_GATHER: begin
        ram_raddr = (slot_ext >= DEPTH_X) ? IDX_W'(slot_ext - DEPTH_X)
                                          : slot_ext[IDX_W-1:0];
        rd_issue  = (issue_cnt != rd_total);
        if (walk_done) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_hum && (div_step == STEP_W'(SUM_W - 1))) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_issue = (issue_cnt != rd_total);
        if (walk_done) begin
          state_next = ST_MASK;
        end
      end
      ST_MASK: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      store_interval <= RST_STORE_INTERVAL;
      cold_below     <= RST_COLD_BELOW;
      hot_above      <= RST_HOT_ABOVE;
      dry_below      <= RST_DRY_BELOW;
      humid_above    <= RST_HUMID_ABOVE;
      trend_limit    <= RST_TREND_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STORE_INTERVAL: store_interval <= cfg_data;
        CFG_COLD_BELOW:     cold_below     <= cfg_data[7:0];
        CFG_HOT_ABOVE:      hot_above      <= cfg_data[7:0];
        CFG_DRY_BELOW:      dry_below      <= cfg_data[7:0];
        CFG_HUMID_ABOVE:    humid_above    <= cfg_data[7:0];
        CFG_TREND_LIMIT:    trend_limit    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // Control state of the history and the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      good_read_count <= '0;
      write_slot      <= '0;
      valid_count     <= '0;
      held_trend      <= '0;
      forecast_temp   <= '0;
      forecast_hum    <= '0;
      temp_low        <= '0;
      temp_high       <= '0;
      hum_low         <= '0;
      hum_high        <= '0;
      result_valid    <= 1'b0;
      rd_vld          <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (state == ST_IDLE && sample_valid && read_ok) begin
        good_read_count <= store_hit ? 16'd0 : cnt_inc;
      end
      if (state == ST_STORE) begin
        write_slot <= (write_slot == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : write_slot + 1'b1;
        if (valid_count != CNT_W'(HISTORY_DEPTH)) begin
          valid_count <= valid_count + 1'b1;
        end
      end
      if (state == ST_GATHER && walk_done) begin
        held_trend <= trend_acc;
      end
      if (state == ST_DIVIDE && div_step == STEP_W'(SUM_W - 1)) begin
        if (div_hum) begin
          forecast_hum <= div_q_next[7:0];
        end else begin
          forecast_temp <= div_q_next[7:0];
        end
      end
      if (state == ST_SCAN && rd_vld) begin
        if (rd_k == '0) begin
          temp_low  <= ram_q[7:0];
          temp_high <= ram_q[7:0];
          hum_low   <= ram_q[15:8];
          hum_high  <= ram_q[15:8];
        end else begin
          if (ram_q[7:0] < temp_low)   temp_low  <= ram_q[7:0];
          if (ram_q[7:0] > temp_high)  temp_high <= ram_q[7:0];
          if (ram_q[15:8] < hum_low)   hum_low   <= ram_q[15:8];
          if (ram_q[15:8] > hum_high)  hum_high  <= ram_q[15:8];
        end
      end
      if (state == ST_MASK) begin
        result_valid <= 1'b1;
      end else if (state == ST_RESULT && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Working registers of the shared unit; no reset needed.
  always_ff @(posedge clk) begin
    rd_k      <= issue_cnt;
    issue_cnt <= issue_cnt + CNT_W'(rd_issue);
    case (state)
      ST_IDLE: begin
        cur_ok   <= read_ok;
        cur_temp <= temperature;
        cur_hum  <= humidity;
      end
      ST_STORE: begin
        issue_cnt <= '0;
        sum_t     <= '0;
        sum_h     <= '0;
        trend_acc <= '0;
      end
      ST_GATHER: begin
        if (rd_vld) begin
          if (rd_k < CNT_W'(fcount)) begin
            sum_t <= sum_t + SUM_W'(ram_q[7:0]);
            sum_h <= sum_h + SUM_W'(ram_q[15:8]);
          end
          if (trend_on) begin
            if (rd_k < CNT_W'(TREND_HALF)) begin
              trend_acc <= trend_acc + $signed({3'b000, ram_q[7:0]});
            end else begin
              trend_acc <= trend_acc - $signed({3'b000, ram_q[7:0]});
            end
          end
        end
        if (walk_done) begin
          div_q    <= sum_t;
          div_rem  <= '0;
          div_step <= '0;
          div_hum  <= 1'b0;
        end
      end
      ST_DIVIDE: begin
        issue_cnt <= '0;
        if (div_step == STEP_W'(SUM_W - 1)) begin
          div_q    <= sum_h;
          div_rem  <= '0;
          div_step <= '0;
          div_hum  <= 1'b1;
        end else begin
          div_q    <= div_q_next;
          div_rem  <= div_rem_next;
          div_step <= div_step + 1'b1;
        end
      end
      ST_MASK: begin
        if (cur_ok) begin
          led_mask[0] <= (cur_temp < cold_below);
          led_mask[1] <= (cur_temp >= cold_below) && (cur_temp <= hot_above);
          led_mask[2] <= (cur_temp > hot_above);
          led_mask[3] <= (cur_hum < dry_below);
          led_mask[4] <= (cur_hum > humid_above);
          led_mask[5] <= (trend_mag > {1'b0, trend_limit});
        end else begin
          led_mask <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  slstat_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_history (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_slot),
    .wdata({cur_hum, cur_temp}),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

endmodule

/* sv/slstat_checker.sv */
// ----------------------------------------------------------------------------
// Sensor log statistics checker
// Port-level assertions on the sample and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slstat_checker
  import slstat_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       sample_valid,
  input logic       sample_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic [5:0] led_mask,
  input logic [5:0] entries_stored
);

  // A stalled result stays offered.
  `SLS_ASSERT(a_result_held, clk, rst, result_valid && result_stall |=> result_valid, "result dropped while stalled")

  // No new reading is taken while a result waits.
  `SLS_ASSERT(a_one_in_flight, clk, rst, result_valid |-> sample_stall, "sample taken with result pending")

  // A result never shows in the cycle right after a sample transfer.
  `SLS_ASSERT(a_no_early_result, clk, rst, sample_valid && !sample_stall |=> !result_valid, "result too early")

  // The normal bit excludes the cold and hot bits.
  `SLS_NEVER(a_normal_exclusive, clk, rst, result_valid && led_mask[1] && (led_mask[0] || led_mask[2]), "normal bit with cold or hot")

  // The stored count never passes the history depth.
  `SLS_ASSERT(a_count_bound, clk, rst, result_valid |-> (entries_stored <= 6'(HISTORY_DEPTH)), "entry count beyond depth")

endmodule

bind sensor_log_statistics slstat_checker u_slstat_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample_valid),
  .sample_stall  (sample_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .led_mask      (led_mask),
  .entries_stored(entries_stored)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Sensor log statistics testbench
// Drives readings and register settings into the block, predicts the
// indicator mask and the held statistics of every reading, and compares
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import slstat_pkg::*;
();

  // Bit positions of the indicator mask.
  localparam int LED_COLD   = 0;
  localparam int LED_MID    = 1;
  localparam int LED_HOT    = 2;
  localparam int LED_DRY    = 3;
  localparam int LED_HUMID  = 4;
  localparam int LED_TREND  = 5;

  // A stored reading keeps the block busy through its whole sequence. Add the
  // longest sender gap and receiver stall, and take that several times over.
  localparam int QUIET_LIMIT = 1000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 115;

  // One result as the block reports it.
  typedef struct {
    logic [5:0]         led_mask;
    logic signed [10:0] trend;
    logic [7:0]         fcast_temp;
    logic [7:0]         fcast_hum;
    logic [7:0]         temp_lo;
    logic [7:0]         temp_hi;
    logic [7:0]         hum_lo;
    logic [7:0]         hum_hi;
    logic [5:0]         entries;
  } report_t;

  // Keeps its own copy of the registers, the ring history and the held
  // statistics, and queues the report that each accepted reading must give.
  class reading_log;
    logic [15:0] store_interval;
    logic [7:0]  cold_below, hot_above, dry_below, humid_above;
    logic [9:0]  trend_limit;

    logic [7:0]       temp_log [HISTORY_DEPTH];
    logic [7:0]       hum_log  [HISTORY_DEPTH];
    logic [IDX_W-1:0] slot;
    int               stored;
    logic [15:0]      good_reads;
    report_t          held;
    report_t          due_reports [$];
    int               failures;

    function new();
      store_interval = RST_STORE_INTERVAL;
      cold_below     = RST_COLD_BELOW;
      hot_above      = RST_HOT_ABOVE;
      dry_below      = RST_DRY_BELOW;
      humid_above    = RST_HUMID_ABOVE;
      trend_limit    = RST_TREND_LIMIT;
      slot           = '0;
      stored         = 0;
      good_reads     = '0;
      held           = '{default: '0};
      failures       = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STORE_INTERVAL: store_interval = value;
        CFG_COLD_BELOW:     cold_below     = value[7:0];
        CFG_HOT_ABOVE:      hot_above      = value[7:0];
        CFG_DRY_BELOW:      dry_below      = value[7:0];
        CFG_HUMID_ABOVE:    humid_above    = value[7:0];
        CFG_TREND_LIMIT:    trend_limit    = value[9:0];
        default: ;
      endcase
    endfunction

    // Trend, forecasts and extremes after a store. Slot slot-1 is the newest.
    function void refresh_stats();
      logic [IDX_W-1:0] idx;
      logic [7:0] tl, th, hl, hh;
      int recent, prior, n, sum_t, sum_h, k;
      recent = 0;
      prior  = 0;
      sum_t  = 0;
      sum_h  = 0;
      if (stored >= TREND_SPAN) begin
        for (k = 0; k < TREND_SPAN; k++) begin
          idx = slot - IDX_W'(k + 1);
          if (k < TREND_HALF) recent += temp_log[idx];
          else prior += temp_log[idx];
        end
      end
      held.trend = 11'(recent - prior);
      n = (stored < FORECAST_SPAN) ? stored : FORECAST_SPAN;
      for (k = 0; k < n; k++) begin
        idx = slot - IDX_W'(k + 1);
        sum_t += temp_log[idx];
        sum_h += hum_log[idx];
      end
      held.fcast_temp = 8'(sum_t / n);
      held.fcast_hum  = 8'(sum_h / n);
      // The ring fills from slot 0, so the stored entries are slots
      // 0 to stored-1 whatever their age.
      tl = temp_log[0];
      th = temp_log[0];
      hl = hum_log[0];
      hh = hum_log[0];
      for (k = 1; k < stored; k++) begin
        if (temp_log[k] < tl) tl = temp_log[k];
        if (temp_log[k] > th) th = temp_log[k];
        if (hum_log[k] < hl) hl = hum_log[k];
        if (hum_log[k] > hh) hh = hum_log[k];
      end
      held.temp_lo = tl;
      held.temp_hi = th;
      held.hum_lo  = hl;
      held.hum_hi  = hh;
    endfunction

    function void note_reading(logic ok, logic [7:0] t, logic [7:0] h);
      report_t r;
      int mag;
      if (ok) begin
        good_reads = good_reads + 16'd1;
        if (good_reads >= store_interval) begin
          temp_log[slot] = t;
          hum_log[slot]  = h;
          slot = slot + 1'b1;
          if (stored < HISTORY_DEPTH) stored++;
          good_reads = '0;
          refresh_stats();
        end
      end
      r = held;
      r.led_mask = '0;
      r.entries  = 6'(stored);
      if (ok) begin
        r.led_mask[LED_COLD]  = (t < cold_below);
        r.led_mask[LED_MID]   = (t >= cold_below) && (t <= hot_above);
        r.led_mask[LED_HOT]   = (t > hot_above);
        r.led_mask[LED_DRY]   = (h < dry_below);
        r.led_mask[LED_HUMID] = (h > humid_above);
        mag = (held.trend < 0) ? -int'(held.trend) : int'(held.trend);
        r.led_mask[LED_TREND] = (mag > int'(trend_limit));
      end
      due_reports.push_back(r);
    endfunction

    function void check_field(string field, logic signed [15:0] want,
                              logic signed [15:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        failures++;
        $display("%0t: result transfer with nothing outstanding, mask %0d",
                 $time, got.led_mask);
      end else begin
        want = due_reports.pop_front();
        check_field("led_mask", want.led_mask, got.led_mask);
        check_field("trend_diff", want.trend, got.trend);
        check_field("forecast_temp", want.fcast_temp, got.fcast_temp);
        check_field("forecast_hum", want.fcast_hum, got.fcast_hum);
        check_field("temp_low", want.temp_lo, got.temp_lo);
        check_field("temp_high", want.temp_hi, got.temp_hi);
        check_field("hum_low", want.hum_lo, got.hum_lo);
        check_field("hum_high", want.hum_hi, got.hum_hi);
        check_field("entries_stored", want.entries, got.entries);
      end
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction
  endclass

  // Every input has a known value from time zero.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  sample_valid = 1'b0;
  logic                  read_ok      = 1'b0;
  logic [7:0]            temperature  = '0;
  logic [7:0]            humidity     = '0;
  logic                  result_stall = 1'b0;

  logic                  sample_stall;
  logic                  result_valid;
  logic [5:0]            led_mask;
  logic signed [10:0]    trend_diff;
  logic [7:0]            forecast_temp, forecast_hum;
  logic [7:0]            temp_low, temp_high, hum_low, hum_high;
  logic [5:0]            entries_stored;

  // Chance of idling out of eight on both sides; zero gives a stretch
  // where both channels run flat out.
  int          idle_rate = 0;
  int          stall_left = 0;
  logic [7:0]  walk_temp = 8'd24;
  logic [7:0]  walk_hum  = 8'd55;
  reading_log  readings = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sensor_log_statistics i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .read_ok        (read_ok),
    .temperature    (temperature),
    .humidity       (humidity),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .led_mask       (led_mask),
    .trend_diff     (trend_diff),
    .forecast_temp  (forecast_temp),
    .forecast_hum   (forecast_hum),
    .temp_low       (temp_low),
    .temp_high      (temp_high),
    .hum_low        (hum_low),
    .hum_high       (hum_high),
    .entries_stored (entries_stored)
  );

  // Result side. The outputs are sampled at the edge before the block's own
  // updates land, and the stall for the next edge is chosen in the same step.
  // A stall is held while stall_left counts down.
  always @(posedge clk) begin
    report_t got;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got.led_mask   = led_mask;
        got.trend      = trend_diff;
        got.fcast_temp = forecast_temp;
        got.fcast_hum  = forecast_hum;
        got.temp_lo    = temp_low;
        got.temp_hi    = temp_high;
        got.hum_lo     = hum_low;
        got.hum_hi     = hum_high;
        got.entries    = entries_stored;
        readings.check_report(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
        stall_left = $urandom_range(0, 8);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // One register write per edge. The caller lowers cfg_write after the last
  // write of a group, so no step assigns it twice.
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    readings.set_register(idx, value);
  endtask

  task automatic configure(logic [15:0] interval, logic [7:0] cold, logic [7:0] hot,
                           logic [7:0] dry, logic [7:0] humid, logic [9:0] limit);
    write_reg(CFG_STORE_INTERVAL, interval);
    write_reg(CFG_COLD_BELOW, cold);
    write_reg(CFG_HOT_ABOVE, hot);
    write_reg(CFG_DRY_BELOW, dry);
    write_reg(CFG_HUMID_ABOVE, humid);
    write_reg(CFG_TREND_LIMIT, limit);
    cfg_write <= 1'b0;
  endtask

  // Presents one reading and returns in the step of its transfer. The valid
  // stays high so that the next reading can follow without a bubble.
  task automatic send_reading(logic ok, logic [7:0] t, logic [7:0] h);
    int gap;
    gap = 0;
    if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    read_ok      <= ok;
    temperature  <= t;
    humidity     <= h;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    readings.note_reading(ok, t, h);
  endtask

  // Closes a phase: the valid drops in the step of the last transfer, then
  // every outstanding result is drained before the registers change.
  task automatic drain();
    sample_valid <= 1'b0;
    while (readings.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Slow drift around the current value, which keeps the trend near the
  // limits and the readings near the thresholds.
  function automatic logic [7:0] wander(logic [7:0] from, int span);
    int v;
    v = int'(from) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(10, 80));
    endcase
  endfunction

  function automatic logic [9:0] pick_trend_limit();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'd765;
      2:       return 10'd1023;
      default: return 10'($urandom_range(0, 40));
    endcase
  endfunction

  // Mostly short intervals so that stores are frequent and the ring wraps.
  function automatic logic [15:0] pick_interval();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(1, 3));
      5, 6, 7:       return 16'($urandom_range(4, 12));
      8:             return 16'd1;
      default:       return 16'($urandom_range(13, 40));
    endcase
  endfunction

  // Mostly good readings that drift, with jumps, full-range noise, the
  // extremes of both fields and failed reads mixed in.
  task automatic send_random_reading();
    int pick;
    logic ok;
    logic [7:0] t, h;
    pick = $urandom_range(0, 99);
    ok = ($urandom_range(0, 99) >= 12);
    if (pick < 65) begin
      walk_temp = wander(walk_temp, 4);
      walk_hum  = wander(walk_hum, 5);
    end else if (pick < 75) begin
      walk_temp = wander(walk_temp, 60);
      walk_hum  = wander(walk_hum, 60);
    end else if (pick < 90) begin
      walk_temp = 8'($urandom_range(0, 255));
      walk_hum  = 8'($urandom_range(0, 255));
    end else begin
      walk_temp = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      walk_hum  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    t = walk_temp;
    h = walk_hum;
    // A failed read carries whatever the bus holds.
    if (!ok && $urandom_range(0, 1)) begin
      t = 8'($urandom_range(0, 255));
      h = 8'($urandom_range(0, 255));
    end
    send_reading(ok, t, h);
  endtask

  // Watchdog: the run is stuck when no transfer happens on either channel
  // for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int p, i, count;
    logic [15:0] interval;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values. A failed read before anything is stored shows
    // the cleared statistics. The good reads sit on both sides of every
    // default threshold and cover the field extremes; only the tenth is
    // stored, so the first store happens with a single entry.
    idle_rate = 2;
    send_reading(1'b0, 8'd255, 8'd255);
    send_reading(1'b1, 8'd19, 8'd39);
    send_reading(1'b1, 8'd20, 8'd40);
    send_reading(1'b1, 8'd28, 8'd70);
    send_reading(1'b1, 8'd29, 8'd71);
    send_reading(1'b1, 8'd0, 8'd0);
    send_reading(1'b1, 8'd255, 8'd255);
    send_reading(1'b1, 8'd128, 8'd128);
    send_reading(1'b1, 8'd21, 8'd50);
    send_reading(1'b1, 8'd27, 8'd69);
    send_reading(1'b1, 8'd25, 8'd45);
    drain();

    // Interval zero stores every good read. The thresholds are crossed, so
    // cold and hot can both be set and normal never is. Three zeros then
    // three full-scale readings give the largest rising trend, and three
    // zeros after that the largest falling one; the limit sits one below it.
    configure(16'd0, 8'd255, 8'd0, 8'd255, 8'd0, 10'd764);
    for (i = 0; i < 3; i++) send_reading(1'b1, 8'd0, 8'd0);
    for (i = 0; i < 3; i++) send_reading(1'b1, 8'd255, 8'd255);
    send_reading(1'b0, 8'd0, 8'd0);
    for (i = 0; i < 3; i++) send_reading(1'b1, 8'd0, 8'd0);
    drain();

    // Random phases, each with fresh register settings. One phase uses the
    // largest interval, so nothing is stored and the held values stay put,
    // and one uses interval zero again. The last phase runs without idling.
    for (p = 0; p < NUM_PHASES; p++) begin
      idle_rate = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 4);
      count = PHASE_ITEMS;
      if (p == 2) begin
        interval = 16'hFFFF;
        count = 20;
      end else if (p == 5) begin
        interval = 16'd0;
      end else begin
        interval = pick_interval();
      end
      configure(interval, pick_threshold(), pick_threshold(), pick_threshold(),
                pick_threshold(), pick_trend_limit());
      for (i = 0; i < count; i++) send_random_reading();
      drain();
    end

    repeat (80) @(posedge clk);
    if (readings.failures == 0 && readings.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sensor_log_statistics.f */
+incdir+sv
sv/slstat_pkg.sv
sv/slstat_ram.sv
sv/sensor_log_statistics.sv
sv/slstat_checker.sv
bench/tb_top.sv
